FILE: rtl/core/bhts_pkg.sv
// Package for the bucketed hash table: sizes, widths, status codes,
// entry layout and controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package bhts_pkg;

    localparam int NUM_BUCKETS  = 16;
    localparam int BUCKET_DEPTH = 8;
    localparam int KEY_BYTES    = 8;

    localparam int CFG_W       = 5;
    localparam int CFG_RESET   = 16;
    localparam int KEY_W       = 64;
    localparam int LEN_W       = 4;
    localparam int HANDLE_W    = 16;
    localparam int STATUS_W    = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam int SLOTS  = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int DIV_W  = $clog2(NUM_BUCKETS + 1);
    localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
    localparam int SUM_W  = $clog2(KEY_BYTES * 255 + 1);
    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [LEN_W-1:0]    len;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic    load;
        logic    mod_step;
        logic    ins_write;
        logic    walk_start;
        logic    walk_next;
        logic    res_valid;
        t_status res_code;
    } t_cmd;

    typedef struct packed {
        logic mod_last;
        logic is_lookup;
        logic bucket_full;
        logic bucket_empty;
        logic match;
        logic walk_last;
    } t_stat;

endpackage

FILE: rtl/core/bucketed_hash_table_store_lookup_top.sv
// Top level of the bucketed hash table: controller plus datapath.
// Depends on bhts_pkg, bhts_ctrl, bhts_dp (and bhts_ram through bhts_dp).
//
//  channel   handshake            payload
//  request   start / busy         i_op, i_key, i_key_len, i_handle
//  result    o_valid (1 cycle)    o_status, o_found_handle
//  config    i_cfg_we             i_cfg_wdata (bucket_count)
//
// A request is taken when start is high and busy is low. The hash takes one
// bit of the 11-bit byte sum per cycle in the shared modulo step, then a
// decision state ends an insert or an empty-bucket lookup; any other lookup
// compares one entry per cycle in the entry RAM until a match or the last.
// The result shows on o_valid for one cycle, as the next request may enter.
// Synchronous active-low reset clears all bucket fill counts and sets
// bucket_count to 16; the result side cannot stall.
`timescale 1ns / 1ps

module bucketed_hash_table_store_lookup_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [bhts_pkg::KEY_W-1:0]    i_key,
    input  logic [bhts_pkg::LEN_W-1:0]    i_key_len,
    input  logic [bhts_pkg::HANDLE_W-1:0] i_handle,
    input  logic                          i_cfg_we,
    input  logic [bhts_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                          o_valid,
    output logic [bhts_pkg::STATUS_W-1:0] o_status,
    output logic [bhts_pkg::HANDLE_W-1:0] o_found_handle
);

    bhts_pkg::t_cmd  cmd;
    bhts_pkg::t_stat stat;

    bhts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bhts_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_key_len      (i_key_len),
        .i_handle       (i_handle),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found_handle (o_found_handle)
    );

    a_req_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe without a finished request");

    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != bhts_pkg::ST_FOUND)) |-> (o_found_handle == '0))
        else $error("nonzero handle on a miss or insert");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

FILE: rtl/core/bhts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bhts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bhts_ctrl.sv
// Controller state machine for the bucketed hash table.
// Depends on bhts_pkg; drives bhts_dp through t_cmd and reads t_stat.
`timescale 1ns / 1ps

module bhts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  bhts_pkg::t_stat i_stat,
    output bhts_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_HASH   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_WALK   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.res_code   = bhts_pkg::ST_INSERTED;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_stat.is_lookup) begin
                    o_cmd.res_valid = 1'b1;
                    n_state         = S_IDLE;
                    if (i_stat.bucket_full) begin
                        o_cmd.res_code = bhts_pkg::ST_FULL;
                    end else begin
                        o_cmd.ins_write = 1'b1;
                        o_cmd.res_code  = bhts_pkg::ST_INSERTED;
                    end
                end else if (i_stat.bucket_empty) begin
                    o_cmd.res_valid = 1'b1;
                    o_cmd.res_code  = bhts_pkg::ST_NOT_FOUND;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.match) begin
                    o_cmd.res_valid = 1'b1;
                    o_cmd.res_code  = bhts_pkg::ST_FOUND;
                    n_state         = S_IDLE;
                end else if (i_stat.walk_last) begin
                    o_cmd.res_valid = 1'b1;
                    o_cmd.res_code  = bhts_pkg::ST_NOT_FOUND;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.walk_next = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: rtl/core/bhts_dp.sv
// Datapath for the bucketed hash table: request capture, byte-sum hash with
// bit-serial modulo, bucket fill counters, entry RAM and result registers.
// Depends on bhts_pkg and bhts_ram; controlled by bhts_ctrl.
`timescale 1ns / 1ps

module bhts_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bhts_pkg::t_cmd                    i_cmd,
    output bhts_pkg::t_stat                   o_stat,
    input  logic                              i_op,
    input  logic [bhts_pkg::KEY_W-1:0]        i_key,
    input  logic [bhts_pkg::LEN_W-1:0]        i_key_len,
    input  logic [bhts_pkg::HANDLE_W-1:0]     i_handle,
    input  logic                              i_cfg_we,
    input  logic [bhts_pkg::CFG_W-1:0]        i_cfg_wdata,
    output logic                              o_valid,
    output logic [bhts_pkg::STATUS_W-1:0]     o_status,
    output logic [bhts_pkg::HANDLE_W-1:0]     o_found_handle
);

    logic [bhts_pkg::CFG_W-1:0]    r_cfg;
    logic [bhts_pkg::DIV_W-1:0]    eff_count;

    logic [bhts_pkg::LEN_W-1:0]    len_c;
    logic [bhts_pkg::KEY_W-1:0]    key_m;
    logic [bhts_pkg::SUM_W-1:0]    sum_c;

    logic                          r_op;
    logic [bhts_pkg::KEY_W-1:0]    r_key;
    logic [bhts_pkg::LEN_W-1:0]    r_len;
    logic [bhts_pkg::HANDLE_W-1:0] r_handle;

    logic [bhts_pkg::SUM_W-1:0]    r_sum;
    logic [bhts_pkg::DIV_W-1:0]    r_rem;
    logic [bhts_pkg::STEP_W-1:0]   r_step;
    logic [bhts_pkg::DIV_W:0]      shifted;
    logic [bhts_pkg::DIV_W-1:0]    n_rem;

    logic [bhts_pkg::BKT_W-1:0]    bucket;
    logic [bhts_pkg::FILL_W-1:0]   r_fill [bhts_pkg::NUM_BUCKETS];
    logic [bhts_pkg::FILL_W-1:0]   fill_sel;
    logic [bhts_pkg::ADDR_W-1:0]   base;

    logic [bhts_pkg::FILL_W-1:0]   r_idx;
    logic [bhts_pkg::FILL_W-1:0]   idx_inc;
    logic [bhts_pkg::FILL_W-1:0]   r_walk_fill;

    logic                          ram_re;
    logic [bhts_pkg::ADDR_W-1:0]   ram_raddr;
    logic [bhts_pkg::ADDR_W-1:0]   ram_waddr;
    logic [bhts_pkg::ENTRY_W-1:0]  ram_rdata;
    bhts_pkg::t_entry              wr_entry;
    bhts_pkg::t_entry              rd_entry;

    logic                          r_valid;
    logic [bhts_pkg::STATUS_W-1:0] r_status;
    logic [bhts_pkg::HANDLE_W-1:0] r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bhts_pkg::CFG_W'(bhts_pkg::CFG_RESET);
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            eff_count = bhts_pkg::DIV_W'(1);
        end else if (int'(r_cfg) > bhts_pkg::NUM_BUCKETS) begin
            eff_count = bhts_pkg::DIV_W'(bhts_pkg::NUM_BUCKETS);
        end else begin
            eff_count = bhts_pkg::DIV_W'(r_cfg);
        end
    end

    always_comb begin
        if (i_key_len > bhts_pkg::LEN_W'(bhts_pkg::KEY_BYTES)) begin
            len_c = bhts_pkg::LEN_W'(bhts_pkg::KEY_BYTES);
        end else begin
            len_c = i_key_len;
        end
        key_m = '0;
        sum_c = '0;
        for (int j = 0; j < bhts_pkg::KEY_BYTES; j++) begin
            if (bhts_pkg::LEN_W'(j) < len_c) begin
                key_m[j*8 +: 8] = i_key[j*8 +: 8];
                sum_c = sum_c + bhts_pkg::SUM_W'(i_key[j*8 +: 8]);
            end
        end
    end

    // restoring remainder, one sum bit per step, MSB first
    always_comb begin
        shifted = {r_rem, r_sum[bhts_pkg::SUM_W-1]};
        if (shifted >= {1'b0, eff_count}) begin
            n_rem = bhts_pkg::DIV_W'(shifted - {1'b0, eff_count});
        end else begin
            n_rem = bhts_pkg::DIV_W'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_key    <= key_m;
            r_len    <= len_c;
            r_handle <= i_handle;
            r_sum    <= sum_c;
            r_rem    <= '0;
            r_step   <= bhts_pkg::STEP_W'(bhts_pkg::SUM_W - 1);
        end else if (i_cmd.mod_step) begin
            r_sum  <= r_sum << 1;
            r_rem  <= n_rem;
            r_step <= r_step - bhts_pkg::STEP_W'(1);
        end
    end

    assign bucket   = r_rem[bhts_pkg::BKT_W-1:0];
    assign fill_sel = r_fill[bucket];
    assign base     = bhts_pkg::ADDR_W'(bucket) * bhts_pkg::ADDR_W'(bhts_pkg::BUCKET_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < bhts_pkg::NUM_BUCKETS; b++) begin
                r_fill[b] <= '0;
            end
        end else if (i_cmd.ins_write) begin
            r_fill[bucket] <= fill_sel + bhts_pkg::FILL_W'(1);
        end
    end

    assign idx_inc = r_idx + bhts_pkg::FILL_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_idx       <= '0;
            r_walk_fill <= fill_sel;
        end else if (i_cmd.walk_next) begin
            r_idx <= idx_inc;
        end
    end

    // prefetch the next slot while the current one is compared
    assign ram_re    = i_cmd.walk_start | i_cmd.walk_next;
    assign ram_raddr = i_cmd.walk_start ? base : base + bhts_pkg::ADDR_W'(idx_inc);
    assign ram_waddr = base + bhts_pkg::ADDR_W'(fill_sel);

    always_comb begin
        wr_entry.key    = r_key;
        wr_entry.len    = r_len;
        wr_entry.handle = r_handle;
    end

    bhts_ram #(
        .WIDTH (bhts_pkg::ENTRY_W),
        .DEPTH (bhts_pkg::SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_write),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = bhts_pkg::t_entry'(ram_rdata);

    always_comb begin
        o_stat.mod_last     = (r_step == '0);
        o_stat.is_lookup    = (r_op == bhts_pkg::OP_LOOKUP);
        o_stat.bucket_full  = (fill_sel == bhts_pkg::FILL_W'(bhts_pkg::BUCKET_DEPTH));
        o_stat.bucket_empty = (fill_sel == '0);
        o_stat.match        = (rd_entry.len == r_len) && (rd_entry.key == r_key);
        o_stat.walk_last    = (idx_inc == r_walk_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_valid) begin
            r_status <= i_cmd.res_code;
            if (i_cmd.res_code == bhts_pkg::ST_FOUND) begin
                r_found <= rd_entry.handle;
            end else begin
                r_found <= '0;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_found_handle = r_found;

endmodule

FILE: tb/tb_bucketed_hash_table_store_lookup_top.sv
// Self-checking bench for bucketed_hash_table_store_lookup_top: a driver
// feeds insert and lookup requests, and a monitor compares each result
// with a bucket table predictor. Depends on bhts_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_bucketed_hash_table_store_lookup_top;

    localparam int   PHASE_ITEMS = 140;
    localparam int   POOL_MAX = 40;

    typedef struct {
        logic                          op;
        logic [bhts_pkg::KEY_W-1:0]    key;
        logic [bhts_pkg::LEN_W-1:0]    len;
        logic [bhts_pkg::HANDLE_W-1:0] handle;
    } t_hash_req;

    typedef struct {
        bhts_pkg::t_status             status;
        logic [bhts_pkg::HANDLE_W-1:0] handle;
    } t_lookup_result;

    typedef struct {
        logic [bhts_pkg::KEY_W-1:0] key;
        int                         len;
    } t_pool_key;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          i_op = bhts_pkg::OP_INSERT;
    logic [bhts_pkg::KEY_W-1:0]    i_key = '0;
    logic [bhts_pkg::LEN_W-1:0]    i_key_len = '0;
    logic [bhts_pkg::HANDLE_W-1:0] i_handle = '0;
    logic                          i_cfg_we = 1'b0;
    logic [bhts_pkg::CFG_W-1:0]    i_cfg_wdata = '0;
    logic                          o_valid;
    logic [bhts_pkg::STATUS_W-1:0] o_status;
    logic [bhts_pkg::HANDLE_W-1:0] o_found_handle;

    t_hash_req      req_queue[$];
    t_lookup_result expected_results[$];
    t_pool_key      key_pool[$];

    logic [bhts_pkg::KEY_W-1:0]    slot_key[bhts_pkg::SLOTS];
    int                            slot_len[bhts_pkg::SLOTS];
    logic [bhts_pkg::HANDLE_W-1:0] slot_handle[bhts_pkg::SLOTS];
    int                            bucket_fill[bhts_pkg::NUM_BUCKETS];
    logic [bhts_pkg::CFG_W-1:0]    bucket_count_cfg = bhts_pkg::CFG_W'(bhts_pkg::CFG_RESET);

    int sender_idle_pct = 0;
    int error_count = 0;
    int requests_seen = 0;
    int n_inserted = 0;
    int n_found = 0;
    int n_missed = 0;
    int n_full = 0;

    bucketed_hash_table_store_lookup_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_key_len      (i_key_len),
        .i_handle       (i_handle),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found_handle (o_found_handle)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int clamp_key_len(logic [bhts_pkg::LEN_W-1:0] raw);
        return (int'(raw) > bhts_pkg::KEY_BYTES) ? bhts_pkg::KEY_BYTES : int'(raw);
    endfunction

    function automatic logic [bhts_pkg::KEY_W-1:0] valid_byte_mask(int len);
        if (len >= bhts_pkg::KEY_BYTES)
            return '1;
        return (64'd1 << (len * 8)) - 64'd1;
    endfunction

    function automatic int bucket_for(logic [bhts_pkg::KEY_W-1:0] key, int len);
        int sum;
        int buckets;
        sum = 0;
        for (int i = 0; i < len; i++)
            sum += int'(key[i*8 +: 8]);
        buckets = int'(bucket_count_cfg);
        if (buckets == 0)
            buckets = 1;
        if (buckets > bhts_pkg::NUM_BUCKETS)
            buckets = bhts_pkg::NUM_BUCKETS;
        return sum % buckets;
    endfunction

    function automatic void predict_request(t_hash_req r);
        int                         len;
        int                         bkt;
        int                         fill;
        int                         slot;
        logic [bhts_pkg::KEY_W-1:0] key;
        t_lookup_result             res;
        len = clamp_key_len(r.len);
        key = r.key & valid_byte_mask(len);
        bkt = bucket_for(key, len);
        fill = bucket_fill[bkt];
        res.status = bhts_pkg::ST_NOT_FOUND;
        res.handle = '0;
        if (r.op == bhts_pkg::OP_INSERT) begin
            if (fill >= bhts_pkg::BUCKET_DEPTH) begin
                res.status = bhts_pkg::ST_FULL;
                n_full++;
            end else begin
                slot = bkt * bhts_pkg::BUCKET_DEPTH + fill;
                slot_key[slot] = key;
                slot_len[slot] = len;
                slot_handle[slot] = r.handle;
                bucket_fill[bkt] = fill + 1;
                res.status = bhts_pkg::ST_INSERTED;
                n_inserted++;
            end
        end else begin
            for (int i = 0; i < fill; i++) begin
                slot = bkt * bhts_pkg::BUCKET_DEPTH + i;
                if (res.status == bhts_pkg::ST_NOT_FOUND && slot_len[slot] == len &&
                    slot_key[slot] == key) begin
                    res.status = bhts_pkg::ST_FOUND;
                    res.handle = slot_handle[slot];
                end
            end
            if (res.status == bhts_pkg::ST_FOUND)
                n_found++;
            else
                n_missed++;
        end
        requests_seen++;
        expected_results.push_back(res);
    endfunction

    function automatic void push_request(logic op, logic [bhts_pkg::KEY_W-1:0] key,
                                         logic [bhts_pkg::LEN_W-1:0] len,
                                         logic [bhts_pkg::HANDLE_W-1:0] handle);
        t_hash_req r;
        r.op = op;
        r.key = key;
        r.len = len;
        r.handle = handle;
        req_queue.push_back(r);
    endfunction

    function automatic void push_random_request();
        t_hash_req                  r;
        t_pool_key                  p;
        int                         eff;
        logic [bhts_pkg::KEY_W-1:0] m;
        r.op = ($urandom_range(99) < 45) ? bhts_pkg::OP_INSERT : bhts_pkg::OP_LOOKUP;
        r.handle = bhts_pkg::HANDLE_W'($urandom);
        if (key_pool.size() != 0 && $urandom_range(99) < 60) begin
            p = key_pool[$urandom_range(key_pool.size() - 1)];
            eff = p.len;
            // probe same bytes under a different length
            if ($urandom_range(99) < 15)
                eff = $urandom_range(bhts_pkg::KEY_BYTES);
            m = valid_byte_mask(eff);
            r.key = (p.key & m) | ({$urandom, $urandom} & ~m);
        end else begin
            eff = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, bhts_pkg::KEY_BYTES);
            r.key = {$urandom, $urandom};
            if (r.op == bhts_pkg::OP_INSERT) begin
                p.key = r.key & valid_byte_mask(eff);
                p.len = eff;
                if (key_pool.size() >= POOL_MAX)
                    key_pool[$urandom_range(POOL_MAX - 1)] = p;
                else
                    key_pool.push_back(p);
            end
        end
        r.len = (eff == bhts_pkg::KEY_BYTES) ?
                bhts_pkg::LEN_W'($urandom_range(bhts_pkg::KEY_BYTES, 15)) :
                bhts_pkg::LEN_W'(eff);
        req_queue.push_back(r);
    endfunction

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (req_queue.size() != 0 || start || busy || expected_results.size() != 0);
    endtask

    task automatic write_bucket_count(logic [bhts_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bucket_count_cfg = value;
    endtask

    always @(posedge i_clk) begin : request_driver
        t_hash_req next_req;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                next_req.op = i_op;
                next_req.key = i_key;
                next_req.len = i_key_len;
                next_req.handle = i_handle;
                predict_request(next_req);
            end
            if (!start || !busy) begin
                if (req_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_req = req_queue.pop_front();
                    start <= 1'b1;
                    i_op <= next_req.op;
                    i_key <= next_req.key;
                    i_key_len <= next_req.len;
                    i_handle <= next_req.handle;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_lookup_result exp_res;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: status %0d, found_handle 0x%h",
                       o_status, o_found_handle);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, actual %0d", exp_res.status, o_status);
                    error_count++;
                end
                if (o_found_handle !== exp_res.handle) begin
                    $error("found_handle: expected 0x%h, actual 0x%h",
                           exp_res.handle, o_found_handle);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic [bhts_pkg::CFG_W-1:0] phase_cfg[8];
        int                         idle_by_phase[4];
        phase_cfg = '{5'd1, 5'd0, 5'd3, 5'd31, 5'd16, 5'd7, 5'd17, 5'd12};
        idle_by_phase = '{0, 67, 0, 10};
        for (int b = 0; b < bhts_pkg::NUM_BUCKETS; b++)
            bucket_fill[b] = 0;

        // empty key, extremes, clamped length, duplicates, length mismatch
        push_request(bhts_pkg::OP_LOOKUP, 64'd0, 4'd0, 16'h0000);
        push_request(bhts_pkg::OP_INSERT, 64'hDEAD_BEEF_0000_0000, 4'd0, 16'hFFFF);
        push_request(bhts_pkg::OP_LOOKUP, 64'h1234_5678_9ABC_DEF0, 4'd0, 16'h5555);
        push_request(bhts_pkg::OP_INSERT, '1, 4'd8, 16'h0000);
        push_request(bhts_pkg::OP_LOOKUP, '1, 4'd15, 16'hFFFF);
        push_request(bhts_pkg::OP_LOOKUP, '1, 4'd7, 16'h0000);
        push_request(bhts_pkg::OP_INSERT, 64'd0, 4'd8, 16'hA5A5);
        push_request(bhts_pkg::OP_LOOKUP, 64'd0, 4'd0, 16'h0000);
        push_request(bhts_pkg::OP_LOOKUP, 64'd0, 4'd9, 16'h0000);
        push_request(bhts_pkg::OP_INSERT, 64'hFFFF_FF01, 4'd1, 16'h0001);
        push_request(bhts_pkg::OP_INSERT, 64'h01, 4'd1, 16'h0002);
        push_request(bhts_pkg::OP_LOOKUP, 64'h01, 4'd1, 16'h0000);
        push_request(bhts_pkg::OP_LOOKUP, 64'h0001, 4'd2, 16'h0000);
        // fill one bucket past its depth
        for (int i = 0; i <= bhts_pkg::BUCKET_DEPTH; i++)
            push_request(bhts_pkg::OP_INSERT, bhts_pkg::KEY_W'(i * 16 + 5), 4'd1,
                         bhts_pkg::HANDLE_W'(16'h0100 + i));
        push_request(bhts_pkg::OP_LOOKUP,
                     bhts_pkg::KEY_W'((bhts_pkg::BUCKET_DEPTH - 1) * 16 + 5), 4'd1, 16'h0000);
        push_request(bhts_pkg::OP_LOOKUP,
                     bhts_pkg::KEY_W'(bhts_pkg::BUCKET_DEPTH * 16 + 5), 4'd1, 16'h0000);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            write_bucket_count(phase_cfg[ph]);
            @(negedge i_clk);
            sender_idle_pct = idle_by_phase[ph % 4];
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_random_request();
            wait_drained();
        end

        repeat (40) @(negedge i_clk);
        $display("Ran %0d requests over 8 bucket count settings: %0d inserted, %0d full",
                 requests_seen, n_inserted, n_full);
        $display("Lookups: %0d found, %0d not found", n_found, n_missed);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
